// ===== design/swms_pkg.sv =====
// Shared widths, defaults, tree sizing helpers and pipeline types for the spread tracker.
`timescale 1ns / 1ps
package swms_pkg;

    localparam int SAMPLE_W       = 31;
    localparam int CFG_W          = 7;
    localparam int WINDOW_MAX_DEF = 64;

    // Per-stage tag that travels beside the window reduction
    typedef struct packed {
        logic valid;
        logic last;
        logic full;
    } t_meta;

    // Number of radix-4 levels needed to cover n leaves
    function automatic int f_tree_levels(input int n);
        int l;
        int p;
        l = 1;
        p = 4;
        for (int i = 0; i < 8; i++) begin
            if (p < n) begin
                p = p * 4;
                l = l + 1;
            end
        end
        return l;
    endfunction

    // Offset of level j inside the flattened node array of a tree with p leaves
    function automatic int f_tree_base(input int p, input int j);
        int b;
        b = 0;
        for (int t = 0; t < 8; t++) begin
            if (t < j) begin
                b = b + (p >> (2 * (t + 1)));
            end
        end
        return b;
    endfunction

    function automatic logic [SAMPLE_W-1:0] f_min2(input logic [SAMPLE_W-1:0] a,
                                                   input logic [SAMPLE_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [SAMPLE_W-1:0] f_max2(input logic [SAMPLE_W-1:0] a,
                                                   input logic [SAMPLE_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== design/swms_minmax_tree.sv =====
// Registered radix-4 min/max reduction over the newest window entries.
`timescale 1ns / 1ps
module swms_minmax_tree #(
    parameter int DEPTH = swms_pkg::WINDOW_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [swms_pkg::SAMPLE_W-1:0] i_store [DEPTH],
    input  logic [$clog2(DEPTH+1)-1:0]    i_len,
    output logic [swms_pkg::SAMPLE_W-1:0] o_lo,
    output logic [swms_pkg::SAMPLE_W-1:0] o_hi
);
    import swms_pkg::*;

    localparam int LV    = f_tree_levels(DEPTH);
    localparam int P     = 1 << (2 * LV);
    localparam int NODES = (P - 1) / 3;

    logic [SAMPLE_W-1:0] w_leaf_lo [P];
    logic [SAMPLE_W-1:0] w_leaf_hi [P];
    logic [SAMPLE_W-1:0] r_lo [NODES];
    logic [SAMPLE_W-1:0] r_hi [NODES];

    // Mask entries outside the window: neutral values for min and max
    for (genvar k = 0; k < P; k++) begin : g_leaf
        if (k < DEPTH) begin : g_real
            assign w_leaf_lo[k] = (32'(k) < 32'(i_len)) ? i_store[k] : '1;
            assign w_leaf_hi[k] = (32'(k) < 32'(i_len)) ? i_store[k] : '0;
        end else begin : g_pad
            assign w_leaf_lo[k] = '1;
            assign w_leaf_hi[k] = '0;
        end
    end

    // Reduce four to one per level, one register per level
    for (genvar j = 0; j < LV; j++) begin : g_lvl
        localparam int N     = P >> (2 * (j + 1));
        localparam int BASE  = f_tree_base(P, j);
        localparam int PBASE = f_tree_base(P, (j > 0) ? j - 1 : 0);
        for (genvar i = 0; i < N; i++) begin : g_node
            if (j == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_lo[BASE+i] <= f_min2(f_min2(w_leaf_lo[4*i],   w_leaf_lo[4*i+1]),
                                               f_min2(w_leaf_lo[4*i+2], w_leaf_lo[4*i+3]));
                        r_hi[BASE+i] <= f_max2(f_max2(w_leaf_hi[4*i],   w_leaf_hi[4*i+1]),
                                               f_max2(w_leaf_hi[4*i+2], w_leaf_hi[4*i+3]));
                    end
                end
            end else begin : g_inner
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_lo[BASE+i] <= f_min2(f_min2(r_lo[PBASE+4*i],   r_lo[PBASE+4*i+1]),
                                               f_min2(r_lo[PBASE+4*i+2], r_lo[PBASE+4*i+3]));
                        r_hi[BASE+i] <= f_max2(f_max2(r_hi[PBASE+4*i],   r_hi[PBASE+4*i+1]),
                                               f_max2(r_hi[PBASE+4*i+2], r_hi[PBASE+4*i+3]));
                    end
                end
            end
        end
    end

    assign o_lo = r_lo[NODES-1];
    assign o_hi = r_hi[NODES-1];

endmodule

// ===== design/sliding_window_max_spread.sv =====
// Top level: sample window, pipelined min/max reduction and best-spread tracking.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  input   | in        | i_valid / o_stall     | i_sample[30:0], i_last
//  result  | out       | o_valid / i_stall     | o_best_spread[30:0], o_found
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_data[6:0] (window_length)
//
// One item per cycle while o_stall is low. After its last item is accepted, a result
// passes the store, LV radix-4 levels (3 at WINDOW_MAX = 64) and output register.
// Synchronous active-low reset clears control, counts and the window length (to 1).
// The pipeline holds only when a result waits stalled in the output register
// and the next last item reaches the tail of the reduction.
`timescale 1ns / 1ps
module sliding_window_max_spread #(
    parameter int WINDOW_MAX = swms_pkg::WINDOW_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [swms_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [swms_pkg::SAMPLE_W-1:0] o_best_spread,
    output logic                          o_found,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swms_pkg::CFG_W-1:0]    i_cfg_data
);
    import swms_pkg::*;

    localparam int LV = f_tree_levels(WINDOW_MAX);
    localparam int CW = $clog2(WINDOW_MAX + 1);

    logic [CFG_W-1:0]    r_window_length;
    logic [SAMPLE_W-1:0] r_store [WINDOW_MAX];
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [CW-1:0]       w_len;
    t_meta               r_meta [LV+1];
    t_meta               n_meta0;
    t_meta               w_tail;
    logic [SAMPLE_W-1:0] w_lo;
    logic [SAMPLE_W-1:0] w_hi;
    logic [SAMPLE_W-1:0] w_spread;
    logic [SAMPLE_W-1:0] r_best;
    logic [SAMPLE_W-1:0] n_best;
    logic                r_seen;
    logic                n_seen;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_spread;
    logic                r_out_found;
    logic                w_en;
    logic                w_accept;

    // Hold the pipeline only when the tail needs an occupied, stalled output
    assign w_tail   = r_meta[LV];
    assign w_en     = !(w_tail.valid && w_tail.last && r_out_valid && i_stall);
    assign w_accept = i_valid && w_en;
    assign o_stall  = !w_en;

    // Configuration register, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            r_window_length <= i_cfg_data;
        end
    end

    // Clamp window length to 1..WINDOW_MAX
    always_comb begin
        if (r_window_length == '0) begin
            w_len = CW'(1);
        end else if (32'(r_window_length) > 32'(WINDOW_MAX)) begin
            w_len = CW'(WINDOW_MAX);
        end else begin
            w_len = CW'(r_window_length);
        end
    end

    // Advance the sample shift line on each accepted item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_store[0] <= i_sample;
            for (int k = 1; k < WINDOW_MAX; k++) begin
                r_store[k] <= r_store[k-1];
            end
        end
    end

    // Count samples of the current sequence, saturating
    assign n_count = (r_count == CW'(WINDOW_MAX)) ? r_count : r_count + 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= i_last ? '0 : n_count;
        end
    end

    // Tag each stage: valid, last, and whether a full window is present
    always_comb begin
        n_meta0.valid = i_valid;
        n_meta0.last  = i_last;
        n_meta0.full  = (n_count >= w_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= LV; j++) begin
                r_meta[j] <= '0;
            end
        end else if (w_en) begin
            r_meta[0] <= n_meta0;
            for (int j = 1; j <= LV; j++) begin
                r_meta[j] <= r_meta[j-1];
            end
        end
    end

    // Window length travels with its item into the reduction
    logic [CW-1:0] r_s0_len;
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s0_len <= w_len;
        end
    end

    swms_minmax_tree #(
        .DEPTH (WINDOW_MAX)
    ) u_tree (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_store (r_store),
        .i_len   (r_s0_len),
        .o_lo    (w_lo),
        .o_hi    (w_hi)
    );

    // Fold the window spread into the best so far
    assign w_spread = w_hi - w_lo;
    always_comb begin
        n_best = r_best;
        n_seen = r_seen;
        if (w_tail.full) begin
            n_seen = 1'b1;
            if (!r_seen || (w_spread > r_best)) begin
                n_best = w_spread;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
            r_seen <= 1'b0;
        end else if (w_en && w_tail.valid) begin
            if (w_tail.last) begin
                r_best <= '0;
                r_seen <= 1'b0;
            end else begin
                r_best <= n_best;
                r_seen <= n_seen;
            end
        end
    end

    // Output register: load on a last item, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en && w_tail.valid && w_tail.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_tail.valid && w_tail.last) begin
            r_out_spread <= n_seen ? n_best : '0;
            r_out_found  <= n_seen;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_best_spread = r_out_spread;
    assign o_found       = r_out_found;

endmodule

// ===== test/sliding_window_max_spread_tb.sv =====
// Self-checking testbench for the sliding-window max spread tracker.
`timescale 1ns / 1ps
module sliding_window_max_spread_tb;
    import swms_pkg::*;

    localparam int                  WIN_DEPTH     = WINDOW_MAX_DEF;
    localparam int                  SETTLE_CYCLES = 12;  // reduction depth plus margin
    localparam int                  HOLD_CYCLES   = 300;
    localparam int                  PHASE_ITEMS   = 80;
    localparam logic [SAMPLE_W-1:0] SMP_MAX       = 31'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] ALT_A         = 31'h2AAA_AAAA;
    localparam logic [SAMPLE_W-1:0] ALT_B         = 31'h5555_5555;

    typedef enum bit {ROW_ITEM = 1'b0, ROW_CFG = 1'b1} t_row_kind;

    typedef struct packed {
        logic [SAMPLE_W-1:0] spread;
        logic                found;
    } t_spread_rec;

    typedef struct packed {
        t_row_kind           kind;
        logic [CFG_W-1:0]    cfg;
        logic [SAMPLE_W-1:0] smp;
        logic                lst;
        logic                typed;
        logic [SAMPLE_W-1:0] t_spread;
        logic                t_found;
    } t_dir_row;

    // Directed rows: kind, length, sample, last, typed, spread, found
    localparam int DIR_N = 23;
    localparam t_dir_row DIR_TAB [DIR_N] = '{
        {ROW_ITEM, 7'd0,   31'd5,   1'b1, 1'b1, 31'd0,   1'b1},
        {ROW_CFG,  7'd3,   31'd0,   1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   SMP_MAX, 1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   31'd0,   1'b1, 1'b1, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   31'd0,   1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   SMP_MAX, 1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   SMP_MAX, 1'b1, 1'b1, SMP_MAX, 1'b1},
        {ROW_ITEM, 7'd0,   31'd10,  1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   31'd20,  1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_CFG,  7'd2,   31'd0,   1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   31'd5,   1'b1, 1'b0, 31'd0,   1'b0},
        {ROW_CFG,  7'd0,   31'd0,   1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   31'd7,   1'b1, 1'b1, 31'd0,   1'b1},
        {ROW_CFG,  7'd127, 31'd0,   1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   31'd3,   1'b1, 1'b1, 31'd0,   1'b0},
        {ROW_CFG,  7'd65,  31'd0,   1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   ALT_B,   1'b1, 1'b1, 31'd0,   1'b0},
        {ROW_CFG,  7'd1,   31'd0,   1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   ALT_A,   1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   ALT_B,   1'b1, 1'b1, 31'd0,   1'b1},
        {ROW_CFG,  7'd2,   31'd0,   1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   ALT_A,   1'b0, 1'b0, 31'd0,   1'b0},
        {ROW_ITEM, 7'd0,   ALT_B,   1'b1, 1'b0, 31'd0,   1'b0}
    };

    // Window lengths of the random phases, extremes and out-of-range codes included
    localparam int PHASE_N = 12;
    localparam logic [CFG_W-1:0] PHASE_LEN [PHASE_N] = '{
        7'd1, 7'd2, 7'd64, 7'd3, 7'd0, 7'd127, 7'd8, 7'd65, 7'd33, 7'd1, 7'd4, 7'd64
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [SAMPLE_W-1:0] i_sample;
    logic                i_last;
    logic                o_valid;
    logic                i_stall;
    logic [SAMPLE_W-1:0] o_best_spread;
    logic                o_found;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data;

    // Predictor state
    logic [SAMPLE_W-1:0] window_hist [WIN_DEPTH];
    int unsigned         seq_fill;
    logic [SAMPLE_W-1:0] best_acc;
    bit                  window_seen;
    logic [CFG_W-1:0]    win_len;

    t_spread_rec spread_due [$];
    int          mismatch_cnt;
    int          send_idle_pct;
    int          stall_pct;
    bit          hold_req;

    sliding_window_max_spread u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_best_spread (o_best_spread),
        .o_found       (o_found),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Shift one sample into the window and update the best spread; report on last
    function automatic bit advance_window(input logic [SAMPLE_W-1:0] smp, input bit lst,
                                          output t_spread_rec rec);
        int                  len;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        len = (win_len == 0) ? 1 : ((win_len > WIN_DEPTH) ? WIN_DEPTH : int'(win_len));
        for (int k = WIN_DEPTH - 1; k > 0; k--) begin
            window_hist[k] = window_hist[k-1];
        end
        window_hist[0] = smp;
        if (seq_fill < WIN_DEPTH) begin
            seq_fill++;
        end
        if (seq_fill >= len) begin
            lo = window_hist[0];
            hi = window_hist[0];
            for (int k = 1; k < len; k++) begin
                if (window_hist[k] < lo) lo = window_hist[k];
                if (window_hist[k] > hi) hi = window_hist[k];
            end
            if (!window_seen || (hi - lo) > best_acc) begin
                best_acc = hi - lo;
            end
            window_seen = 1'b1;
        end
        rec.spread = window_seen ? best_acc : '0;
        rec.found  = window_seen;
        if (lst) begin
            seq_fill    = 0;
            best_acc    = '0;
            window_seen = 1'b0;
        end
        return lst;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(3))
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($urandom_range(15));
            2: return $urandom_range(1) ? SMP_MAX : '0;
            default: return SMP_MAX - SAMPLE_W'($urandom_range(255));
        endcase
    endfunction

    // Offer one item after a random gap, hold it until accepted, then predict
    task automatic push_item(input logic [SAMPLE_W-1:0] smp, input bit lst,
                             output bit got, output t_spread_rec rec);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= smp;
        i_last   <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        got = advance_window(smp, lst, rec);
    endtask

    task automatic send_random(input bit lst);
        bit          got;
        t_spread_rec rec;
        push_item(rand_sample(), lst, got, rec);
        if (got) spread_due = {spread_due, rec};
    endtask

    // Drain all results and let the reduction settle before a register write
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (spread_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        win_len = v;
    endtask

    // Receiver: random stalls, or a long hold-off on request
    initial begin : stall_gen
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_result
        t_spread_rec want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (spread_due.size() == 0) begin
                $display("%0t: unexpected result spread=%0d found=%0d",
                         $time, o_best_spread, o_found);
                mismatch_cnt++;
            end else begin
                want = spread_due.pop_front();
                if (o_best_spread !== want.spread) begin
                    $display("%0t: best_spread expected %0d, got %0d",
                             $time, want.spread, o_best_spread);
                    mismatch_cnt++;
                end
                if (o_found !== want.found) begin
                    $display("%0t: found expected %0d, got %0d",
                             $time, want.found, o_found);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row    row;
        bit          got;
        t_spread_rec rec;
        t_spread_rec typed_rec;
        int          sent;
        int          seq_len;
        int          eff_len;
        int          r;

        mismatch_cnt  = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        seq_fill      = 0;
        best_acc      = '0;
        window_seen   = 1'b0;
        win_len       = 7'd1;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        i_last      <= 1'b0;
        i_stall     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int i = 0; i < DIR_N; i++) begin
            row = DIR_TAB[i];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_len(row.cfg);
            end else begin
                push_item(row.smp, row.lst, got, rec);
                typed_rec.spread = row.t_spread;
                typed_rec.found  = row.t_found;
                if (got) spread_due = {spread_due, (row.typed ? typed_rec : rec)};
            end
        end

        // Random phases, each under its own window length and idling mode
        for (int p = 0; p < PHASE_N; p++) begin
            wait_idle();
            write_len(PHASE_LEN[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 17; stall_pct = 17; end
            endcase
            // Hold the receiver off while short sequences keep coming
            if (p == 0) hold_req = 1'b1;
            eff_len = (PHASE_LEN[p] == 0) ? 1 :
                      ((PHASE_LEN[p] > WIN_DEPTH) ? WIN_DEPTH : int'(PHASE_LEN[p]));
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(99);
                if (r < 15) begin
                    seq_len = (eff_len > 1) ? $urandom_range(eff_len - 1, 1) : 1;
                end else if (r < 88) begin
                    seq_len = eff_len + $urandom_range(8);
                end else begin
                    seq_len = $urandom_range(WIN_DEPTH + 16, WIN_DEPTH + 1);
                end
                for (int n = 0; n < seq_len; n++) begin
                    send_random(n == seq_len - 1);
                end
                sent += seq_len;
            end
            // Leave a sequence open across the next length change
            if ($urandom_range(1)) begin
                repeat ($urandom_range(3, 1)) send_random(1'b0);
            end
        end

        i_valid <= 1'b0;
        while (spread_due.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
